// File: rtl/swft_pkg.sv
// ----------------------------------------------------------------------------
// swft_pkg
// Shared types and constants of the sorted word frequency table.
// ----------------------------------------------------------------------------
package swft_pkg;

  localparam int DEF_MAX_ENTRIES = 1024;
  localparam int DEF_WORD_LEN    = 32;

  localparam logic [1:0] FUNC_TEXT = 2'd0;
  localparam logic [1:0] FUNC_EOT  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_TRUNC = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_BAD   = 2'd3;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [9:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [31:0] word_count;
    logic        is_new;
    logic [10:0] entries_used;
    logic [7:0]  letter;
    logic        last;
    logic [1:0]  status;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_HIT,
    ST_FULL,
    ST_SHRD,
    ST_SHWR,
    ST_INS,
    ST_RDRD,
    ST_OUT,
    ST_BAD
  } state_t;

endpackage

// File: rtl/sorted_word_frequency_table_top.sv
// ----------------------------------------------------------------------------
// sorted_word_frequency_table_top
// Word counter over a byte stream, table kept sorted in a row memory.
// ----------------------------------------------------------------------------
//  channel   | direction | payload | handshake
//  request   | in        | req     | req_valid / req_stall
//  result    | out       | res     | res_valid / res_stall
//
// a text byte or a closing byte with no pending word is handled in idle.
// a closed word runs a binary search, each probe a memory read, then a
// compare; an insert moves up each entry above the slot (read, then write),
// then writes the new entry; this work is serialised by the single memory
// port pair. a read fetches the entry, then gives one result per letter.
// rst is synchronous; memories need no clearing pass.
// a held result stalls only the step that has to produce the next one.
module sorted_word_frequency_table_top #(
  parameter int MAX_ENTRIES = swft_pkg::DEF_MAX_ENTRIES,
  parameter int WORD_LEN    = swft_pkg::DEF_WORD_LEN
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  swft_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_stall,
  output swft_pkg::res_t res
);
  import swft_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int BP_W  = $clog2(WORD_LEN);
  localparam int LEN_W = $clog2(WORD_LEN + 1);
  localparam int ROW_W = WORD_LEN * 8;

  logic [ROW_W-1:0] word_mem [MAX_ENTRIES];
  logic [31:0]      cnt_mem  [MAX_ENTRIES];

  state_t state, state_next;

  logic [7:0]       pend [WORD_LEN];
  logic [LEN_W-1:0] pend_len;
  logic             in_word;
  logic             pend_trunc;

  logic [ROW_W-1:0] key;
  logic             key_trunc;
  logic [CNT_W-1:0] distinct, lo, hi, pos;
  logic [IDX_W-1:0] mid, rd_idx;
  logic [BP_W-1:0]  k;
  logic [ROW_W-1:0] rd_word;
  logic [31:0]      rd_cnt;

  logic             mem_rd, mem_wr;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [ROW_W-1:0] wr_word;
  logic [31:0]      wr_cnt;
  logic             emit;
  res_t             emit_res;

  logic             accept, is_letter, is_upper, closing, is_read, bad_idx;
  logic             out_free, found, greater, lo_lt_hi;
  logic [CNT_W-1:0] mid_full;
  logic [7:0]       cur_byte, nxt_byte, folded;
  logic             cur_last;
  logic [ROW_W-1:0] key_next;

  assign accept    = req_valid && !req_stall;
  assign is_upper  = (req.char_code >= CH_UP_A) && (req.char_code <= CH_UP_Z);
  assign is_letter = is_upper ||
                     ((req.char_code >= CH_LO_A) && (req.char_code <= CH_LO_Z));
  assign folded    = is_upper ? req.char_code + 8'd32 : req.char_code;
  assign closing   = in_word && (((req.func == FUNC_TEXT) && !is_letter) ||
                                 (req.func == FUNC_EOT));
  assign is_read   = (req.func == FUNC_READ);
  assign bad_idx   = 32'(req.entry_index) >= 32'(distinct);
  assign out_free  = !res_valid || !res_stall;
  assign lo_lt_hi  = lo < hi;
  assign mid_full  = lo + ((hi - lo) >> 1);
  assign found     = (key == rd_word);
  assign greater   = (key > rd_word);

  // first byte of a word sits in the top bits so a plain compare orders like strcmp
  always_comb begin
    for (int i = 0; i < WORD_LEN; i++) begin
      key_next[ROW_W-1-8*i -: 8] = (LEN_W'(i) < pend_len) ? pend[i] : 8'd0;
    end
  end

  always_comb begin
    cur_byte = rd_word[ROW_W-1-8*int'(k) -: 8];
    nxt_byte = 8'd0;
    if (int'(k) < WORD_LEN - 1) begin
      nxt_byte = rd_word[ROW_W-9-8*int'(k) -: 8];
    end
    cur_last = (int'(k) == WORD_LEN - 1) || (nxt_byte == 8'd0);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && closing) begin
          state_next = ST_SRCH;
        end else if (accept && is_read) begin
          state_next = bad_idx ? ST_BAD : ST_RDRD;
        end
      end
      ST_SRCH: begin
        priority if (lo_lt_hi) state_next = ST_CMP;
        else if (32'(distinct) == 32'(MAX_ENTRIES)) state_next = ST_FULL;
        else if (distinct == lo) state_next = ST_INS;
        else state_next = ST_SHRD;
      end
      ST_CMP:  state_next = found ? ST_HIT : ST_SRCH;
      ST_SHRD: state_next = ST_SHWR;
      ST_SHWR: state_next = ((pos - CNT_W'(1)) == lo) ? ST_INS : ST_SHRD;
      ST_RDRD: state_next = ST_OUT;
      ST_OUT:  if (out_free && cur_last) state_next = ST_IDLE;
      ST_HIT, ST_FULL, ST_INS, ST_BAD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory control and result generation
  always_comb begin
    req_stall = 1'b1;
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    rd_addr   = mid;
    wr_addr   = mid;
    wr_word   = key;
    wr_cnt    = rd_cnt;
    emit      = 1'b0;
    emit_res  = '0;
    emit_res.entries_used = 11'(distinct);
    emit_res.last         = 1'b1;
    unique case (state)
      ST_IDLE: req_stall = 1'b0;
      ST_SRCH: begin
        mem_rd  = lo_lt_hi;
        rd_addr = mid_full[IDX_W-1:0];
      end
      ST_HIT: begin
        emit   = out_free;
        mem_wr = out_free;
        wr_cnt = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 32'd1;
        emit_res.word_count = wr_cnt;
        emit_res.status     = key_trunc ? STAT_TRUNC : STAT_OK;
      end
      ST_FULL: begin
        emit = out_free;
        emit_res.status = STAT_FULL;
      end
      ST_SHRD: begin
        mem_rd  = 1'b1;
        rd_addr = IDX_W'(pos - CNT_W'(1));
      end
      ST_SHWR: begin
        mem_wr  = 1'b1;
        wr_addr = pos[IDX_W-1:0];
        wr_word = rd_word;
        wr_cnt  = rd_cnt;
      end
      ST_INS: begin
        emit    = out_free;
        mem_wr  = out_free;
        wr_addr = lo[IDX_W-1:0];
        wr_word = key;
        wr_cnt  = 32'd1;
        emit_res.word_count   = 32'd1;
        emit_res.is_new       = 1'b1;
        emit_res.entries_used = 11'(distinct + CNT_W'(1));
        emit_res.status       = key_trunc ? STAT_TRUNC : STAT_OK;
      end
      ST_RDRD: begin
        mem_rd  = 1'b1;
        rd_addr = rd_idx;
      end
      ST_OUT: begin
        emit = out_free;
        emit_res.word_count = rd_cnt;
        emit_res.letter     = cur_byte;
        emit_res.last       = cur_last;
      end
      ST_BAD: begin
        emit = out_free;
        emit_res.status = STAT_BAD;
      end
      ST_CMP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      word_mem[wr_addr] <= wr_word;
      cnt_mem[wr_addr]  <= wr_cnt;
    end
    if (mem_rd) begin
      rd_word <= word_mem[rd_addr];
      rd_cnt  <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_len   <= '0;
      in_word    <= 1'b0;
      pend_trunc <= 1'b0;
      distinct   <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (accept && (req.func == FUNC_TEXT) && is_letter) begin
        in_word <= 1'b1;
        if (32'(pend_len) < 32'(WORD_LEN)) begin
          pend_len <= pend_len + LEN_W'(1);
        end else begin
          pend_trunc <= 1'b1;
        end
      end else if (accept && closing) begin
        in_word    <= 1'b0;
        pend_len   <= '0;
        pend_trunc <= 1'b0;
      end
      if ((state == ST_INS) && out_free) begin
        distinct <= distinct + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_res;
    end
    if (accept && (req.func == FUNC_TEXT) && is_letter &&
        (32'(pend_len) < 32'(WORD_LEN))) begin
      pend[pend_len[BP_W-1:0]] <= folded;
    end
    if (accept && closing) begin
      key       <= key_next;
      key_trunc <= pend_trunc;
      lo        <= '0;
      hi        <= distinct;
    end
    if (accept && is_read) begin
      rd_idx <= IDX_W'(req.entry_index);
      k      <= '0;
    end
    if (state == ST_SRCH) begin
      mid <= mid_full[IDX_W-1:0];
      pos <= distinct;
    end
    if ((state == ST_CMP) && !found) begin
      if (greater) begin
        lo <= CNT_W'(mid) + CNT_W'(1);
      end else begin
        hi <= CNT_W'(mid);
      end
    end
    if (state == ST_SHWR) begin
      pos <= pos - CNT_W'(1);
    end
    if ((state == ST_OUT) && out_free) begin
      k <= k + BP_W'(1);
    end
  end

endmodule

// File: rtl/swft_checker.sv
// ----------------------------------------------------------------------------
// swft_checker
// Port-level checks on the word frequency table results.
// ----------------------------------------------------------------------------
module swft_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input swft_pkg::req_t req,
  input logic           res_valid,
  input logic           res_stall,
  input swft_pkg::res_t res
);
  import swft_pkg::*;

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_bad: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == STAT_BAD) |->
      res.last && (res.word_count == 32'd0) && (res.letter == 8'd0))
    else $error("bad index result malformed");

  a_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == STAT_FULL) |->
      !res.is_new && (res.word_count == 32'd0) && res.last)
    else $error("dropped word result malformed");

  a_new: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_new |->
      (res.word_count == 32'd1) && (res.entries_used != 11'd0) && res.last)
    else $error("new word result malformed");

endmodule

bind sorted_word_frequency_table_top swft_checker u_swft_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted word frequency table: a clocked driver
// and monitor with random idling, a shadow table that predicts every result,
// directed words and random text.
// ----------------------------------------------------------------------------
module tb;
  import swft_pkg::*;

  localparam int NENT       = DEF_MAX_ENTRIES;
  localparam int WLEN       = DEF_WORD_LEN;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 400;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic res_valid;
  logic res_stall;
  res_t res;

  sorted_word_frequency_table_top i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  // shadow table, words packed with the first byte at the top so that
  // an unsigned compare orders them as a byte compare does
  bit [8*WLEN-1:0] tab_word [NENT];
  bit [31:0]       tab_cnt  [NENT];
  int              n_words;
  bit [8*WLEN-1:0] pend_word;
  int              pend_len;
  bit              in_word;
  bit              pend_trunc;

  req_t text_q [$];
  res_t expected_q [$];
  int   errors;
  int   send_idle;
  int   recv_stall;
  bit   hold_req;
  bit   hold_done;
  int   hold_left;
  int   idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic res_t mk_res(bit [31:0] cnt, bit nw, bit [7:0] ltr, bit lst,
                                  logic [1:0] st);
    res_t r;
    r.word_count   = cnt;
    r.is_new       = nw;
    r.entries_used = n_words[10:0];
    r.letter       = ltr;
    r.last         = lst;
    r.status       = st;
    return r;
  endfunction

  task automatic close_word();
    bit [8*WLEN-1:0] key;
    logic [1:0]      st;
    int              lo;
    int              hi;
    int              mid;
    key = pend_word;
    st = pend_trunc ? STAT_TRUNC : STAT_OK;
    pend_word = '0;
    pend_len = 0;
    in_word = 1'b0;
    pend_trunc = 1'b0;
    lo = 0;
    hi = n_words;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key == tab_word[mid]) begin
        if (tab_cnt[mid] != COUNT_MAX) tab_cnt[mid]++;
        expected_q.push_back(mk_res(tab_cnt[mid], 1'b0, 8'd0, 1'b1, st));
        return;
      end
      if (key > tab_word[mid]) lo = mid + 1;
      else hi = mid;
    end
    if (n_words >= NENT) begin
      expected_q.push_back(mk_res(32'd0, 1'b0, 8'd0, 1'b1, STAT_FULL));
      return;
    end
    for (int i = n_words; i > lo; i--) begin
      tab_word[i] = tab_word[i-1];
      tab_cnt[i] = tab_cnt[i-1];
    end
    tab_word[lo] = key;
    tab_cnt[lo] = 32'd1;
    n_words++;
    expected_q.push_back(mk_res(32'd1, 1'b1, 8'd0, 1'b1, st));
  endtask

  task automatic predict_request(req_t r);
    bit [7:0] ch;
    bit [7:0] b;
    bit [7:0] nb;
    bit       up;
    ch = r.char_code;
    up = (ch >= CH_UP_A) && (ch <= CH_UP_Z);
    case (r.func)
      FUNC_TEXT: begin
        if (up || ((ch >= CH_LO_A) && (ch <= CH_LO_Z))) begin
          if (pend_len < WLEN) begin
            pend_word[8*WLEN-1-8*pend_len -: 8] = up ? ch - CH_UP_A + CH_LO_A : ch;
            pend_len++;
          end else begin
            pend_trunc = 1'b1;
          end
          in_word = 1'b1;
        end else if (in_word) begin
          close_word();
        end
      end
      FUNC_EOT: begin
        if (in_word) close_word();
      end
      FUNC_READ: begin
        if (r.entry_index >= n_words) begin
          expected_q.push_back(mk_res(32'd0, 1'b0, 8'd0, 1'b1, STAT_BAD));
        end else begin
          for (int j = 0; j < WLEN; j++) begin
            b = tab_word[r.entry_index][8*WLEN-1-8*j -: 8];
            if (b == 8'd0) break;
            nb = (j + 1 < WLEN) ? tab_word[r.entry_index][8*WLEN-9-8*j -: 8] : 8'd0;
            expected_q.push_back(mk_res(tab_cnt[r.entry_index], 1'b0, b,
                                        nb == 8'd0, STAT_OK));
          end
        end
      end
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else begin
      if (req_valid && !req_stall) predict_request(req);
      if (!req_valid || !req_stall) begin
        if (text_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          req <= text_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = expected_q.pop_front();
          if (res.word_count !== e.word_count)
            report($sformatf("word_count %0h exp %0h", res.word_count, e.word_count));
          if (res.is_new !== e.is_new)
            report($sformatf("is_new %0b exp %0b", res.is_new, e.is_new));
          if (res.entries_used !== e.entries_used)
            report($sformatf("entries_used %0d exp %0d", res.entries_used,
                             e.entries_used));
          if (res.letter !== e.letter)
            report($sformatf("letter %0h exp %0h", res.letter, e.letter));
          if (res.last !== e.last)
            report($sformatf("last %0b exp %0b", res.last, e.last));
          if (res.status !== e.status)
            report($sformatf("status %0d exp %0d", res.status, e.status));
        end
      end
      if (hold_req && !hold_done) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
        res_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= $urandom_range(99) < recv_stall;
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sorted_word_frequency_table_top test failed");
        $finish;
      end
    end
  end

  function automatic req_t mk_req(logic [1:0] f, bit [7:0] ch, bit [9:0] idx);
    req_t r;
    r.func = f;
    r.char_code = ch;
    r.entry_index = idx;
    return r;
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++)
      text_q.push_back(mk_req(FUNC_TEXT, s[i], 10'($urandom)));
  endtask

  function automatic bit [7:0] non_letter();
    bit [7:0] c;
    do c = 8'($urandom);
    while ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z));
    return c;
  endfunction

  task automatic add_random_word();
    int n;
    bit [7:0] c;
    n = ($urandom_range(9) == 0) ? $urandom_range(33, 45) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      // small alphabet so words repeat
      c = 8'(CH_LO_A + $urandom_range(5));
      if (i == 0 && $urandom_range(7) == 0) c = CH_LO_Z;
      if ($urandom_range(1)) c = c - CH_LO_A + CH_UP_A;
      text_q.push_back(mk_req(FUNC_TEXT, c, 10'($urandom)));
    end
    if ($urandom_range(5) == 0) text_q.push_back(mk_req(FUNC_EOT, 8'($urandom), 10'($urandom)));
    else text_q.push_back(mk_req(FUNC_TEXT, non_letter(), 10'($urandom)));
  endtask

  task automatic drain();
    while (text_q.size() > 0 || req_valid || expected_q.size() > 0) @(posedge clk);
  endtask

  task automatic random_phase(int nitems, int s_idle, int r_stall);
    int r;
    send_idle = s_idle;
    recv_stall = r_stall;
    for (int k = 0; k < nitems; k++) begin
      r = $urandom_range(99);
      if (r < 70) add_random_word();
      else if (r < 82) text_q.push_back(mk_req(FUNC_READ, 8'($urandom),
                                               10'($urandom_range(0, 40))));
      else if (r < 86) text_q.push_back(mk_req(FUNC_READ, 8'($urandom), 10'($urandom)));
      else if (r < 93) text_q.push_back(mk_req(FUNC_TEXT, non_letter(), 10'($urandom)));
      else if (r < 96) text_q.push_back(mk_req(FUNC_EOT, 8'($urandom), 10'($urandom)));
      else text_q.push_back(mk_req(2'd3, 8'($urandom), 10'($urandom)));
    end
    drain();
  endtask

  initial begin
    errors = 0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 1'b0;
    n_words = 0;
    pend_word = '0;
    pend_len = 0;
    in_word = 1'b0;
    pend_trunc = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: case folding, prefixes, letter bounds, closers, long word
    text_q.push_back(mk_req(FUNC_EOT, 8'h00, 10'h000));
    text_q.push_back(mk_req(FUNC_READ, 8'hFF, 10'd0));
    add_text("Hello hELLo@abc[ab`b{");
    add_text("AZaz");
    text_q.push_back(mk_req(FUNC_TEXT, 8'hFF, 10'h3FF));
    add_text("Q");
    text_q.push_back(mk_req(FUNC_EOT, 8'hFF, 10'h3FF));
    text_q.push_back(mk_req(2'd3, 8'h41, 10'h3FF));
    add_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKL");
    text_q.push_back(mk_req(FUNC_TEXT, 8'h00, 10'h000));
    text_q.push_back(mk_req(FUNC_READ, 8'h00, 10'd0));
    text_q.push_back(mk_req(FUNC_READ, 8'h00, 10'd3));
    text_q.push_back(mk_req(FUNC_READ, 8'h00, 10'h3FF));
    drain();

    // random text under several idling patterns
    hold_req = 1'b1;
    random_phase(4, 0, 0);
    random_phase(4, 85, 0);
    random_phase(4, 0, 85);
    random_phase(4, 21, 21);

    repeat (200) @(posedge clk);
    if (errors == 0) $display("sorted_word_frequency_table_top test passed");
    else $display("sorted_word_frequency_table_top test failed");
    $finish;
  end

endmodule
